// ===== design/nsr_pkg.sv =====
// Shared constants and pipeline payload types for the Newton square root block.
`timescale 1ns / 1ps
package nsr_pkg;

  localparam int ITERATIONS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int X_W     = 32;
  localparam int ROOT_W  = 31;
  localparam int PROD_W  = 2 * ROOT_W;
  localparam int SQ_W    = PROD_W - FRAC_BITS;
  localparam int DELTA_W = SQ_W + 2;
  localparam int QUO_W   = ROOT_W + FRAC_BITS;
  localparam int EST_W   = QUO_W + 2;
  localparam int NFULL_W = DELTA_W + FRAC_BITS - 1;
  localparam int REM_W   = ROOT_W + 1;
  localparam int TENTH   = ((1 << FRAC_BITS) + 5) / 10;

  localparam logic signed [EST_W-1:0] EST_MAX = EST_W'((64'd1 << ROOT_W) - 64'd1);

  // Estimate handed from one Newton step to the next
  typedef struct packed {
    logic                    valid;
    logic                    pos;
    logic signed [X_W-1:0]   x;
    logic signed [EST_W-1:0] est;
  } nsr_est_t;

  // Working set of one divider cell
  typedef struct packed {
    logic                  valid;
    logic                  pos;
    logic signed [X_W-1:0] x;
    logic [ROOT_W-1:0]     div;
    logic                  neg;
    logic [QUO_W-1:0]      num;
    logic [REM_W-1:0]      rem;
    logic [QUO_W-1:0]      quo;
  } nsr_cell_t;

endpackage

// ===== design/nsr_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per clock while enabled.
`timescale 1ns / 1ps
module nsr_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  nsr_pkg::nsr_cell_t cin,
  output nsr_pkg::nsr_cell_t cout
);

  logic [nsr_pkg::REM_W-1:0] trial;
  logic                      ge;
  nsr_pkg::nsr_cell_t        cell_next;

  always_comb begin
    trial = {cin.rem[nsr_pkg::REM_W-2:0], cin.num[nsr_pkg::QUO_W-1]};
    ge    = trial >= {1'b0, cin.div};
    cell_next      = cin;
    cell_next.rem  = ge ? (trial - {1'b0, cin.div}) : trial;
    cell_next.num  = {cin.num[nsr_pkg::QUO_W-2:0], 1'b0};
    cell_next.quo  = {cin.quo[nsr_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else if (en) begin
      cout <= cell_next;
    end
  end

endmodule

// ===== design/nsr_step.sv =====
// One Newton step: clamp and square, form the correction, divide, update.
`timescale 1ns / 1ps
module nsr_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  nsr_pkg::nsr_est_t sin,
  output nsr_pkg::nsr_est_t sout
);

  logic signed [nsr_pkg::EST_W-1:0] e_cl;
  logic                             a_valid;
  logic                             a_pos;
  logic signed [nsr_pkg::X_W-1:0]   a_x;
  logic [nsr_pkg::ROOT_W-1:0]       a_e;
  logic [nsr_pkg::PROD_W-1:0]       a_prod;

  logic [nsr_pkg::SQ_W-1:0]            sq;
  logic signed [nsr_pkg::DELTA_W-1:0]  delta;
  logic [nsr_pkg::DELTA_W-1:0]         mag;
  logic [nsr_pkg::NFULL_W-1:0]         nfull;
  nsr_pkg::nsr_cell_t                  b_next;
  nsr_pkg::nsr_cell_t                  chain [nsr_pkg::QUO_W+1];

  logic signed [nsr_pkg::EST_W-1:0] q_mag;
  logic signed [nsr_pkg::EST_W-1:0] e_ext;
  nsr_pkg::nsr_est_t                out_next;

  // Clamp the estimate into the usable range, then square it
  always_comb begin
    e_cl = sin.est;
    if (e_cl <= 0) begin
      e_cl = nsr_pkg::EST_W'(nsr_pkg::TENTH);
    end
    if (e_cl > nsr_pkg::EST_MAX) begin
      e_cl = nsr_pkg::EST_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pos  <= sin.pos;
      a_x    <= sin.x;
      a_e    <= e_cl[nsr_pkg::ROOT_W-1:0];
      a_prod <= nsr_pkg::PROD_W'(e_cl[nsr_pkg::ROOT_W-1:0])
              * nsr_pkg::PROD_W'(e_cl[nsr_pkg::ROOT_W-1:0]);
    end
  end

  // Correction delta * 2^(F-1) as sign and magnitude for the divider
  always_comb begin
    sq    = a_prod[nsr_pkg::PROD_W-1:nsr_pkg::FRAC_BITS];
    delta = nsr_pkg::DELTA_W'(a_x) - $signed({2'b00, sq});
    mag   = delta[nsr_pkg::DELTA_W-1] ? nsr_pkg::DELTA_W'(-delta) : nsr_pkg::DELTA_W'(delta);
    nfull = nsr_pkg::NFULL_W'(mag) << (nsr_pkg::FRAC_BITS - 1);
    b_next.valid = a_valid;
    b_next.pos   = a_pos;
    b_next.x     = a_x;
    b_next.div   = a_e;
    b_next.neg   = delta[nsr_pkg::DELTA_W-1];
    b_next.num   = nfull[nsr_pkg::QUO_W-1:0];
    b_next.rem   = nsr_pkg::REM_W'(nfull >> nsr_pkg::QUO_W);
    b_next.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else if (en) begin
      chain[0] <= b_next;
    end
  end

  for (genvar i = 0; i < nsr_pkg::QUO_W; i++) begin : g_div
    nsr_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .cin  (chain[i]),
      .cout (chain[i+1])
    );
  end

  // Apply the signed correction
  always_comb begin
    q_mag = $signed(nsr_pkg::EST_W'(chain[nsr_pkg::QUO_W].quo));
    e_ext = $signed(nsr_pkg::EST_W'(chain[nsr_pkg::QUO_W].div));
    out_next.valid = chain[nsr_pkg::QUO_W].valid;
    out_next.pos   = chain[nsr_pkg::QUO_W].pos;
    out_next.x     = chain[nsr_pkg::QUO_W].x;
    out_next.est   = chain[nsr_pkg::QUO_W].neg ? (e_ext - q_mag) : (e_ext + q_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sout <= '0;
    end else if (en) begin
      sout <= out_next;
    end
  end

endmodule

// ===== design/newton_square_root.sv =====
// Top level of the pipelined Newton-Raphson fixed-point square root.
`timescale 1ns / 1ps
// Square root of a signed Q15.16 operand by ten Newton steps, returned as an
// unsigned Q15.16 value; a zero or negative operand gives zero. The block is a
// fully unrolled pipeline: one input register, ten identical Newton steps and
// an output register. Each step squares its estimate in one multiplier stage,
// forms the correction in one stage, divides through a row of 47 one-bit
// restoring cells and adds the correction in one more stage. A new transaction
// is taken every clock while the pipeline is not held. The whole pipeline holds
// while a result waits in the output register and the sink is not ready.
module newton_square_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] root_value, [31] zero
);

  logic              en;
  nsr_pkg::nsr_est_t lane [nsr_pkg::ITERATIONS+1];
  nsr_pkg::nsr_est_t in_next;
  logic [nsr_pkg::ROOT_W-1:0] root_next;

  // Advance everything whenever the output slot is free or being emptied
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Seed the estimate with the operand itself
  always_comb begin
    in_next.valid = s_axis_tvalid;
    in_next.pos   = !s_axis_tdata[31] && (s_axis_tdata != '0);
    in_next.x     = $signed(s_axis_tdata);
    in_next.est   = nsr_pkg::EST_W'($signed(s_axis_tdata));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane[0] <= '0;
    end else if (en) begin
      lane[0] <= in_next;
    end
  end

  for (genvar i = 0; i < nsr_pkg::ITERATIONS; i++) begin : g_step
    nsr_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .sin  (lane[i]),
      .sout (lane[i+1])
    );
  end

  // Saturate the final estimate; drop it for a non-positive operand
  always_comb begin
    if (!lane[nsr_pkg::ITERATIONS].pos || lane[nsr_pkg::ITERATIONS].est < 0) begin
      root_next = '0;
    end else if (lane[nsr_pkg::ITERATIONS].est > nsr_pkg::EST_MAX) begin
      root_next = '1;
    end else begin
      root_next = lane[nsr_pkg::ITERATIONS].est[nsr_pkg::ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= lane[nsr_pkg::ITERATIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {1'b0, root_next};
    end
  end

  a_neg_not_pos: assert property (@(posedge clk) disable iff (rst)
    (en && s_axis_tdata[31]) |=> !lane[0].pos)
    else $error("negative operand marked positive");

  a_hold_tail: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(lane[nsr_pkg::ITERATIONS]))
    else $error("pipeline moved while output stalled");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (en && lane[nsr_pkg::ITERATIONS].valid && !lane[nsr_pkg::ITERATIONS].pos)
      |=> (m_axis_tdata == '0))
    else $error("non-positive operand gave non-zero root");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the pipelined Newton square root block.
`timescale 1ns / 1ps
module testbench;

  localparam int CLK_HALF         = 10;
  localparam int PIPE_LATENCY     = 502;
  localparam int WATCHDOG_MAX     = 40000;
  localparam int RANDOM_ITEMS     = 1350;
  localparam int HOLD_PHASE_ITEMS = 600;
  localparam int LONG_HOLD        = 1500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [31:0] operand_q[$];
  logic [30:0] root_q[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  bit          hold_request = 1'b0;
  bit          in_taken = 1'b0;

  newton_square_root dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // Newton-Raphson root with 64-bit signed intermediates
  function automatic logic [30:0] newton_root(logic signed [31:0] x_in);
    longint x, est, sq, delta, stp;
    x = x_in;
    if (x <= 0) return '0;
    est = x;
    for (int i = 0; i < nsr_pkg::ITERATIONS; i++) begin
      if (est <= 0) est = nsr_pkg::TENTH;
      if (est > 64'sh7FFF_FFFF) est = 64'sh7FFF_FFFF;
      sq = (est * est) >> nsr_pkg::FRAC_BITS;
      delta = x - sq;
      stp = (delta * (64'sd1 <<< nsr_pkg::FRAC_BITS)) / (2 * est);
      est = est + stp;
    end
    if (est < 0) return '0;
    if (est > 64'sh7FFF_FFFF) return 31'h7FFF_FFFF;
    return est[30:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 1023);
      3: return 32'h8000_0000 + $urandom_range(0, 1023);
      4: return 32'h1 << $urandom_range(0, 30);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  // Note each input transaction at the edge that accepts it
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // Driver: offer the head of the queue, advance on each accepted transaction
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (in_taken) begin
      void'(operand_q.pop_front());
      if (operand_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end else if (!s_axis_tvalid && operand_q.size() > 0
                 && $urandom_range(0, 99) >= send_idle_pct) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= operand_q[0];
    end
  end

  // Receiver readiness, with a long hold-off counted here on request
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) hold_left <= LONG_HOLD;
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    logic [30:0] want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) root_q.push_back(newton_root(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (root_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = root_q.pop_front();
          if (m_axis_tdata[30:0] !== want)
            report_mismatch("root_value", m_axis_tdata, {1'b0, want});
          if (m_axis_tdata[31] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata, {1'b0, want});
        end
      end
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (operand_q.size() != 0 || s_axis_tvalid || root_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] directed[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Extremes, zero, negatives, one, one tenth and tiny values
    directed = {32'h0, 32'h1, 32'h2, 32'h0001_0000, 32'h0000_199A, 32'h0004_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF,
                32'h8000_0001, 32'hFFFF_0000, 32'h0000_FFFF, 32'h4000_0000,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003, 32'h0064_0000,
                32'h0000_8000, 32'h0000_4000};
    foreach (directed[i]) operand_q.push_back(directed[i]);
    drain();

    // Phases: free flow with a long hold-off, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 30 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 30 : 0;
      if (ph == 0) begin
        for (int n = 0; n < HOLD_PHASE_ITEMS; n++) operand_q.push_back(pick_operand());
        hold_request = 1'b1;
        wait (hold_left > 0);
        hold_request = 1'b0;
      end else begin
        for (int n = 0; n < (RANDOM_ITEMS - HOLD_PHASE_ITEMS) / 3; n++)
          operand_q.push_back(pick_operand());
      end
      drain();
    end

    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && root_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/nsr_pkg.sv
design/nsr_div_cell.sv
design/nsr_step.sv
design/newton_square_root.sv
sim/testbench.sv
